/* rtl/positional_circular_list_unit_defines.svh */
// Assertion macros used by the pcl_checker file.
`ifndef POSITIONAL_CIRCULAR_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_CIRCULAR_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pcl_pkg.sv */
package pcl_pkg;

   localparam int CAPACITY    = 64;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 8;
   localparam int IDX_W       = 8;
   localparam int OUT_COUNT_W = 9;
   localparam int CMP_W       = POS_W + 1;

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_DELETE   = 2'd1,
      CMD_COUNT    = 2'd2,
      CMD_TRAVERSE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_code_type;

   typedef enum logic [2:0] {
      RD_PTR    = 3'd0,
      RD_PTR_P1 = 3'd1,
      RD_PTR_P2 = 3'd2,
      RD_PTR_M1 = 3'd3,
      RD_PTR_M2 = 3'd4
   } rd_sel_type;

   typedef enum logic {
      WR_FROM_RAM = 1'b0,
      WR_FROM_REQ = 1'b1
   } wr_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD       = 3'd0,
      PTR_LOAD_COUNT = 3'd1,
      PTR_LOAD_POS   = 3'd2,
      PTR_CLEAR      = 3'd3,
      PTR_INC        = 3'd4,
      PTR_DEC        = 3'd5
   } ptr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD  = 2'd0,
      CNT_INC   = 2'd1,
      CNT_DEC   = 2'd2,
      CNT_CLEAR = 2'd3
   } count_op_type;

   typedef struct packed {
      logic            load_req;
      logic            rd_en;
      rd_sel_type      rd_sel;
      logic            wr_en;
      wr_sel_type      wr_sel;
      ptr_op_type      ptr_op;
      count_op_type    count_op;
      logic            out_load;
      logic            out_trav;
      status_code_type out_status;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    count_zero;
      logic    count_one;
      logic    count_full;
      logic    pos_gt_count;
      logic    pos_eq_count;
      logic    pos_ge_count;
      logic    pos_last;
      logic    ins_more;
      logic    del_more;
      logic    trav_last;
      logic    out_free;
   } dp_status_type;

endpackage

/* rtl/pcl_ram.sv */
module pcl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pcl_ctrl.sv */
module pcl_ctrl
   import pcl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_DISPATCH  = 10'b00_0000_0010,
      S_INS_RD    = 10'b00_0000_0100,
      S_INS_WR    = 10'b00_0000_1000,
      S_INS_PUT   = 10'b00_0001_0000,
      S_DEL_RD    = 10'b00_0010_0000,
      S_DEL_WR    = 10'b00_0100_0000,
      S_TRAV_RD   = 10'b00_1000_0000,
      S_TRAV_EMIT = 10'b01_0000_0000,
      S_RESP      = 10'b10_0000_0000
   } state_type;

   state_type       state_ff, state_in;
   status_code_type status_ff, status_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in           = state_ff;
      status_in          = status_ff;
      dp_cmd.load_req    = 1'b0;
      dp_cmd.rd_en       = 1'b0;
      dp_cmd.rd_sel      = RD_PTR;
      dp_cmd.wr_en       = 1'b0;
      dp_cmd.wr_sel      = WR_FROM_RAM;
      dp_cmd.ptr_op      = PTR_HOLD;
      dp_cmd.count_op    = CNT_HOLD;
      dp_cmd.out_load    = 1'b0;
      dp_cmd.out_trav    = 1'b0;
      dp_cmd.out_status  = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load_req = 1'b1;
               state_in        = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (dp_status.cmd)
               CMD_INSERT: begin
                  if (dp_status.count_zero) begin
                     dp_cmd.ptr_op = PTR_LOAD_COUNT;
                     state_in      = S_INS_PUT;
                  end else if (dp_status.count_full) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else if (dp_status.pos_gt_count) begin
                     status_in = ST_RANGE;
                     state_in  = S_RESP;
                  end else begin
                     dp_cmd.ptr_op = PTR_LOAD_COUNT;
                     state_in      = dp_status.pos_eq_count ? S_INS_PUT : S_INS_RD;
                  end
               end
               CMD_DELETE: begin
                  if (dp_status.count_zero) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else if (dp_status.count_one) begin
                     dp_cmd.count_op = CNT_CLEAR;
                     status_in       = ST_OK;
                     state_in        = S_RESP;
                  end else if (dp_status.pos_ge_count) begin
                     status_in = ST_RANGE;
                     state_in  = S_RESP;
                  end else if (dp_status.pos_last) begin
                     dp_cmd.count_op = CNT_DEC;
                     status_in       = ST_OK;
                     state_in        = S_RESP;
                  end else begin
                     dp_cmd.ptr_op = PTR_LOAD_POS;
                     state_in      = S_DEL_RD;
                  end
               end
               CMD_COUNT: begin
                  status_in = ST_OK;
                  state_in  = S_RESP;
               end
               CMD_TRAVERSE: begin
                  if (dp_status.count_zero) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     dp_cmd.ptr_op = PTR_CLEAR;
                     state_in      = S_TRAV_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_INS_RD: begin
            dp_cmd.rd_en  = 1'b1;
            dp_cmd.rd_sel = RD_PTR_M1;
            state_in      = S_INS_WR;
         end
         S_INS_WR: begin
            dp_cmd.wr_en  = 1'b1;
            dp_cmd.wr_sel = WR_FROM_RAM;
            dp_cmd.ptr_op = PTR_DEC;
            if (dp_status.ins_more) begin
               dp_cmd.rd_en  = 1'b1;
               dp_cmd.rd_sel = RD_PTR_M2;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            dp_cmd.wr_en    = 1'b1;
            dp_cmd.wr_sel   = WR_FROM_REQ;
            dp_cmd.count_op = CNT_INC;
            status_in       = ST_OK;
            state_in        = S_RESP;
         end
         S_DEL_RD: begin
            dp_cmd.rd_en  = 1'b1;
            dp_cmd.rd_sel = RD_PTR_P1;
            state_in      = S_DEL_WR;
         end
         S_DEL_WR: begin
            dp_cmd.wr_en  = 1'b1;
            dp_cmd.wr_sel = WR_FROM_RAM;
            dp_cmd.ptr_op = PTR_INC;
            if (dp_status.del_more) begin
               dp_cmd.rd_en  = 1'b1;
               dp_cmd.rd_sel = RD_PTR_P2;
            end else begin
               dp_cmd.count_op = CNT_DEC;
               status_in       = ST_OK;
               state_in        = S_RESP;
            end
         end
         S_TRAV_RD: begin
            dp_cmd.rd_en  = 1'b1;
            dp_cmd.rd_sel = RD_PTR;
            state_in      = S_TRAV_EMIT;
         end
         S_TRAV_EMIT: begin
            if (dp_status.out_free) begin
               dp_cmd.out_load   = 1'b1;
               dp_cmd.out_trav   = 1'b1;
               dp_cmd.out_status = ST_OK;
               if (dp_status.trav_last) begin
                  state_in = S_IDLE;
               end else begin
                  dp_cmd.ptr_op = PTR_INC;
                  dp_cmd.rd_en  = 1'b1;
                  dp_cmd.rd_sel = RD_PTR_P1;
               end
            end
         end
         S_RESP: begin
            if (dp_status.out_free) begin
               dp_cmd.out_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

/* rtl/pcl_datapath.sv */
module pcl_datapath
   import pcl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                req_cmd,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_value_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value_out,
   output logic [IDX_W-1:0]          rsp_index_out,
   output logic [OUT_COUNT_W-1:0]    rsp_count_out,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last,
   input  dp_cmd_type                dp_cmd,
   output dp_status_type             dp_status
);

   cmd_type             cmd_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  ptr_ff, ptr_in;
   logic [COUNT_W-1:0]  rd_ptr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic [VALUE_W-1:0]  rd_data;
   logic [CMP_W-1:0]    pos_ext, count_ext, ptr_ext;
   logic                out_free;

   logic                    out_valid_ff;
   logic [VALUE_W-1:0]      out_value_ff;
   logic [IDX_W-1:0]        out_index_ff;
   logic [OUT_COUNT_W-1:0]  out_count_ff;
   status_code_type         out_status_ff;
   logic                    out_last_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         cmd_ff <= cmd_type'(req_cmd);
         pos_ff <= req_position;
         val_ff <= req_value_in;
      end
   end

   always_comb begin
      unique case (dp_cmd.ptr_op)
         PTR_HOLD:       ptr_in = ptr_ff;
         PTR_LOAD_COUNT: ptr_in = count_ff;
         PTR_LOAD_POS:   ptr_in = pos_ff[COUNT_W-1:0];
         PTR_CLEAR:      ptr_in = '0;
         PTR_INC:        ptr_in = ptr_ff + COUNT_W'(1);
         PTR_DEC:        ptr_in = ptr_ff - COUNT_W'(1);
         default:        ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   always_comb begin
      unique case (dp_cmd.count_op)
         CNT_HOLD:  count_in = count_ff;
         CNT_INC:   count_in = count_ff + COUNT_W'(1);
         CNT_DEC:   count_in = count_ff - COUNT_W'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      unique case (dp_cmd.rd_sel)
         RD_PTR:    rd_ptr = ptr_ff;
         RD_PTR_P1: rd_ptr = ptr_ff + COUNT_W'(1);
         RD_PTR_P2: rd_ptr = ptr_ff + COUNT_W'(2);
         RD_PTR_M1: rd_ptr = ptr_ff - COUNT_W'(1);
         RD_PTR_M2: rd_ptr = ptr_ff - COUNT_W'(2);
         default:   rd_ptr = ptr_ff;
      endcase
   end

   assign rd_addr = rd_ptr[ADDR_W-1:0];
   assign wr_data = (dp_cmd.wr_sel == WR_FROM_REQ) ? val_ff : rd_data;

   pcl_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (dp_cmd.wr_en),
      .wr_addr(ptr_ff[ADDR_W-1:0]),
      .wr_data(wr_data),
      .rd_en  (dp_cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign pos_ext   = {1'b0, pos_ff};
   assign count_ext = CMP_W'(count_ff);
   assign ptr_ext   = CMP_W'(ptr_ff);
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      dp_status.cmd          = cmd_ff;
      dp_status.count_zero   = (count_ff == '0);
      dp_status.count_one    = (count_ff == COUNT_W'(1));
      dp_status.count_full   = (count_ff == COUNT_W'(CAPACITY));
      dp_status.pos_gt_count = (pos_ext > count_ext);
      dp_status.pos_eq_count = (pos_ext == count_ext);
      dp_status.pos_ge_count = (pos_ext >= count_ext);
      dp_status.pos_last     = ((pos_ext + CMP_W'(1)) == count_ext);
      dp_status.ins_more     = (ptr_ext > (pos_ext + CMP_W'(1)));
      dp_status.del_more     = ((ptr_ext + CMP_W'(2)) < count_ext);
      dp_status.trav_last    = ((ptr_ext + CMP_W'(1)) == count_ext);
      dp_status.out_free     = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (dp_cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.out_load) begin
         out_count_ff  <= OUT_COUNT_W'(count_ff);
         out_status_ff <= dp_cmd.out_status;
         if (dp_cmd.out_trav) begin
            out_value_ff <= rd_data;
            out_index_ff <= IDX_W'(ptr_ff);
            out_last_ff  <= dp_status.trav_last;
         end else begin
            out_value_ff <= '0;
            out_index_ff <= '0;
            out_last_ff  <= 1'b1;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value_out = out_value_ff;
   assign rsp_index_out = out_index_ff;
   assign rsp_count_out = out_count_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_last      = out_last_ff;

endmodule

/* rtl/positional_circular_list_unit.sv */
// Channel   Handshake             Word
// req       req_valid/req_ready   req_cmd, req_position, req_value_in
// rsp       rsp_valid/rsp_ready   rsp_value_out, rsp_index_out, rsp_count_out,
//                                 rsp_status, rsp_last
//
// One command is worked at a time; req_ready returns once the command's last
// rsp word is loaded. An insert that moves elements first shifts each element
// from its position on up by one; a delete shifts each later element down by
// one; a traverse emits one word per element, in order.
// Synchronous reset empties the list at once; there is no clearing pass.
// A stalled rsp holds its word, and the controller waits for the slot.
module positional_circular_list_unit
   import pcl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_cmd,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_value_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value_out,
   output logic [IDX_W-1:0]          rsp_index_out,
   output logic [OUT_COUNT_W-1:0]    rsp_count_out,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   pcl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .dp_status(dp_status),
      .dp_cmd   (dp_cmd)
   );

   pcl_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_value_in (req_value_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value_out(rsp_value_out),
      .rsp_index_out(rsp_index_out),
      .rsp_count_out(rsp_count_out),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .dp_cmd       (dp_cmd),
      .dp_status    (dp_status)
   );

endmodule

/* rtl/pcl_checker.sv */
`include "positional_circular_list_unit_defines.svh"

module pcl_checker
   import pcl_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_value_out,
   input logic [IDX_W-1:0]          rsp_index_out,
   input logic [OUT_COUNT_W-1:0]    rsp_count_out,
   input logic [1:0]                rsp_status,
   input logic                      rsp_last
);

   `PCL_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready,
      "req_ready stayed high after a word was taken.")
   `PCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_value_out) && $stable(rsp_count_out) &&
      $stable(rsp_status) && $stable(rsp_last),
      "Stalled response word changed.")
   `PCL_ASSERT_NOW(a_empty_word, clock, reset, rsp_valid && (rsp_status == ST_EMPTY),
      (rsp_count_out == '0) && rsp_last,
      "Empty status without zero count and last.")
   `PCL_ASSERT_NOW(a_full_word, clock, reset, rsp_valid && (rsp_status == ST_FULL),
      (rsp_count_out == OUT_COUNT_W'(CAPACITY)) && rsp_last,
      "Full status with wrong count.")
   `PCL_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && (rsp_status != ST_OK),
      (rsp_value_out == '0) && (rsp_index_out == '0),
      "Error word carries an element.")

endmodule

bind positional_circular_list_unit pcl_checker u_checker (.*);

/* sim/list_response_checker.sv */
`timescale 1ns / 100ps

module list_response_checker
   import pcl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [1:0]                req_cmd,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_value_in,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [VALUE_W-1:0] rsp_value_out,
   input  logic [IDX_W-1:0]          rsp_index_out,
   input  logic [OUT_COUNT_W-1:0]    rsp_count_out,
   input  logic [1:0]                rsp_status,
   input  logic                      rsp_last,
   output int                        mismatch_total,
   output int                        words_pending
);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [IDX_W-1:0]          index;
      logic [OUT_COUNT_W-1:0]    count;
      status_code_type           status;
      logic                      last;
   } list_word_type;

   logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
   int unsigned               list_len = 0;
   list_word_type             expected_words [$];
   int                        error_tally = 0;

   task automatic queue_word(logic signed [VALUE_W-1:0] value, int unsigned index,
                             status_code_type status, logic last);
      list_word_type w;
      w.value  = value;
      w.index  = IDX_W'(index);
      w.count  = OUT_COUNT_W'(list_len);
      w.status = status;
      w.last   = last;
      expected_words.push_back(w);
   endtask

   task automatic apply_list_command(cmd_type cmd, logic [POS_W-1:0] pos,
                                     logic signed [VALUE_W-1:0] val);
      int              i;
      status_code_type st;
      case (cmd)
         CMD_INSERT: begin
            if (list_len == 0) begin
               shadow_list[0] = val;
               list_len = 1;
               st = ST_OK;
            end else if (list_len >= CAPACITY) begin
               st = ST_FULL;
            end else if (pos > list_len) begin
               st = ST_RANGE;
            end else begin
               for (i = list_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = val;
               list_len++;
               st = ST_OK;
            end
            queue_word('0, 0, st, 1'b1);
         end
         CMD_DELETE: begin
            if (list_len == 0) begin
               st = ST_EMPTY;
            end else if (list_len == 1) begin
               list_len = 0;
               st = ST_OK;
            end else if (pos >= list_len) begin
               st = ST_RANGE;
            end else begin
               for (i = pos; i + 1 < list_len; i++) shadow_list[i] = shadow_list[i+1];
               list_len--;
               st = ST_OK;
            end
            queue_word('0, 0, st, 1'b1);
         end
         CMD_COUNT: begin
            queue_word('0, 0, ST_OK, 1'b1);
         end
         default: begin
            if (list_len == 0) begin
               queue_word('0, 0, ST_EMPTY, 1'b1);
            end else begin
               for (i = 0; i < list_len; i++)
                  queue_word(shadow_list[i], i, ST_OK, (i + 1 == list_len));
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      list_word_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               if (error_tally < 10)
                  $display("%0t: rsp word with nothing expected: value %0d index %0d count %0d status %0d last %0d",
                           $realtime, rsp_value_out, rsp_index_out, rsp_count_out,
                           rsp_status, rsp_last);
               error_tally++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_value_out !== w.value || rsp_index_out !== w.index ||
                   rsp_count_out !== w.count || rsp_status !== w.status ||
                   rsp_last !== w.last) begin
                  if (error_tally < 10)
                     $display("%0t: rsp word mismatch: value %0d/%0d index %0d/%0d count %0d/%0d status %0d/%0d last %0d/%0d (expected/actual)",
                              $realtime, w.value, rsp_value_out, w.index, rsp_index_out,
                              w.count, rsp_count_out, w.status, rsp_status,
                              w.last, rsp_last);
                  error_tally++;
               end
            end
         end
         if (req_valid && req_ready)
            apply_list_command(cmd_type'(req_cmd), req_position, req_value_in);
      end
      mismatch_total <= error_tally;
      words_pending  <= expected_words.size();
   end

endmodule

/* sim/tb_positional_circular_list_unit.sv */
`timescale 1ns / 100ps

module tb_positional_circular_list_unit;
   import pcl_pkg::*;

   localparam int RANDOM_WORDS = 360;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [1:0]                req_cmd;
   logic [POS_W-1:0]          req_position;
   logic signed [VALUE_W-1:0] req_value_in;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [VALUE_W-1:0] rsp_value_out;
   logic [IDX_W-1:0]          rsp_index_out;
   logic [OUT_COUNT_W-1:0]    rsp_count_out;
   logic [1:0]                rsp_status;
   logic                      rsp_last;
   int                        mismatch_total;
   int                        words_pending;

   int unsigned list_fill;
   int          burst_left;
   logic        valid_dropped;

   positional_circular_list_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_position  (req_position),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_index_out (rsp_index_out),
      .rsp_count_out (rsp_count_out),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   list_response_checker u_list_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_out  (rsp_value_out),
      .rsp_index_out  (rsp_index_out),
      .rsp_count_out  (rsp_count_out),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .mismatch_total (mismatch_total),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("tb_positional_circular_list_unit failed");
      $finish;
   end

   // The receiver stalls on a changing duty, and twice holds off long enough
   // for the block to back up into its input.
   initial begin
      int cyc;
      int ready_pct;
      cyc = 0;
      ready_pct = 100;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 75;
               2: ready_pct = 50;
               default: ready_pct = 25;
            endcase
         end
         if (cyc == 1500 || cyc == 8000) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            cyc += 400;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   task automatic pace_sender();
      int gap;
      valid_dropped = 1'b0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            valid_dropped = 1'b1;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic offer_command(cmd_type cmd, logic [POS_W-1:0] pos,
                                logic signed [VALUE_W-1:0] val);
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_position <= pos;
      req_value_in <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (cmd)
         CMD_INSERT: begin
            if (list_fill == 0) list_fill = 1;
            else if (list_fill < CAPACITY && pos <= list_fill) list_fill++;
         end
         CMD_DELETE: begin
            if (list_fill == 1) list_fill = 0;
            else if (list_fill > 1 && pos < list_fill) list_fill--;
         end
         default: ;
      endcase
      pace_sender();
   endtask

   function automatic logic [POS_W-1:0] pick_position(cmd_type cmd);
      int unsigned limit;
      int unsigned r;
      limit = (cmd == CMD_INSERT) ? list_fill : ((list_fill == 0) ? 0 : list_fill - 1);
      r = $urandom_range(0, 99);
      if (cmd == CMD_COUNT || cmd == CMD_TRAVERSE) return POS_W'($urandom());
      if (r < 10) return '0;
      if (r < 20) return POS_W'(limit);
      if (r < 88) return POS_W'($urandom_range(0, limit));
      return POS_W'($urandom_range(limit + 1, 255));
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) != 0) return $urandom();
      case ($urandom_range(0, 3))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         default: return -1;
      endcase
   endfunction

   initial begin
      int      n;
      int      ins_pct;
      int      del_pct;
      int      roll;
      cmd_type cmd;
      list_fill     = 0;
      burst_left    = 0;
      valid_dropped = 1'b1;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cmd      <= CMD_COUNT;
      req_position <= '0;
      req_value_in <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_command(CMD_TRAVERSE, 8'd0, 32'sd0);
      offer_command(CMD_DELETE, 8'd0, 32'sd0);
      offer_command(CMD_COUNT, 8'd255, -1);
      offer_command(CMD_INSERT, 8'd255, 32'sh7FFF_FFFF);
      offer_command(CMD_INSERT, 8'd0, 32'sh8000_0000);
      offer_command(CMD_INSERT, 8'd2, -1);
      offer_command(CMD_INSERT, 8'd1, 32'sd0);
      offer_command(CMD_INSERT, 8'd9, 32'sd77);
      offer_command(CMD_INSERT, 8'd2, 32'sd12345);
      offer_command(CMD_TRAVERSE, 8'd255, 32'sh5555_5555);
      offer_command(CMD_DELETE, 8'd5, 32'sd0);
      offer_command(CMD_DELETE, 8'd255, 32'sd0);
      offer_command(CMD_DELETE, 8'd0, 32'sd0);
      offer_command(CMD_DELETE, 8'd3, 32'sd0);
      offer_command(CMD_DELETE, 8'd1, 32'sd0);
      offer_command(CMD_COUNT, 8'd0, 32'sd0);
      offer_command(CMD_TRAVERSE, 8'd0, 32'sd0);
      offer_command(CMD_DELETE, 8'd0, 32'sd0);
      offer_command(CMD_DELETE, 8'd200, 32'sd0);
      offer_command(CMD_INSERT, 8'd0, 32'shAAAA_AAAA);
      offer_command(CMD_DELETE, 8'd0, 32'sd0);
      offer_command(CMD_TRAVERSE, 8'd170, 32'sd0);
      offer_command(CMD_COUNT, 8'd85, 32'sh1234_5678);

      // Grow until the list is full and rejects inserts, drain it, then mix.
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n < 150) begin
            ins_pct = 80;
            del_pct = 8;
         end else if (n < 260) begin
            ins_pct = 8;
            del_pct = 80;
         end else begin
            ins_pct = 45;
            del_pct = 35;
         end
         roll = $urandom_range(0, 99);
         if (roll < ins_pct) cmd = CMD_INSERT;
         else if (roll < ins_pct + del_pct) cmd = CMD_DELETE;
         else if (roll < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2) cmd = CMD_COUNT;
         else cmd = CMD_TRAVERSE;
         offer_command(cmd, pick_position(cmd), pick_value());
      end

      if (!valid_dropped) req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_total == 0 && words_pending == 0) begin
         $display("tb_positional_circular_list_unit passed");
      end else begin
         $display("tb_positional_circular_list_unit failed");
      end
      $finish;
   end

endmodule

/* positional_circular_list_unit.f */
+incdir+rtl
rtl/pcl_pkg.sv
rtl/pcl_ram.sv
rtl/pcl_ctrl.sv
rtl/pcl_datapath.sv
rtl/positional_circular_list_unit.sv
rtl/pcl_checker.sv
sim/list_response_checker.sv
sim/tb_positional_circular_list_unit.sv
